// ===== hdl/escape_time_fractal_iterator_macros.svh =====
// Assertion macros shared by the escape-time iterator RTL.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH

// Checked on every clock edge once reset is released.
`define ETFI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, including reset cycles.
`define ETFI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/etfi_pkg.sv =====
// Package: widths, types, codes and saturating helpers for the fractal iterator.
package etfi_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int FRACTION_BITS   = 28;
   localparam int COUNT_WIDTH     = 12;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int MODE_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic [COUNT_WIDTH-1:0]       count_type;
   typedef logic [COUNT_WIDTH:0]         result_type;
   typedef logic [MODE_WIDTH-1:0]        mode_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]   csr_index_type;

   // Control for the shared multiplier
   typedef struct packed {
      logic load;      // capture a new product this cycle
      logic absolute;  // cross output uses the product magnitude
   } mul_ctrl_type;

   // Fractal modes
   localparam mode_type MODE_MANDELBROT = 2'd0;
   localparam mode_type MODE_JULIA      = 2'd1;
   localparam mode_type MODE_PHOENIX    = 2'd2;

   // Register indexes
   localparam csr_index_type CSR_MODE      = 2'd0;
   localparam csr_index_type CSR_MAX_ITER  = 2'd1;
   localparam csr_index_type CSR_JULIA_RE  = 2'd2;
   localparam csr_index_type CSR_JULIA_IM  = 2'd3;

   // Reset values
   localparam mode_type  MODE_RESET     = MODE_MANDELBROT;
   localparam count_type MAX_ITER_RESET = COUNT_WIDTH'(80);
   localparam data_type  JULIA_RE_RESET = DATA_WIDTH'(-136007387);
   localparam data_type  JULIA_IM_RESET = DATA_WIDTH'(139586437);

   // Number range
   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Escape threshold: 4.0, or the largest value when 4.0 does not fit
   localparam data_type FOUR_LIMIT = (FRACTION_BITS + 2 >= DATA_WIDTH - 1) ?
                                     DATA_MAX : data_type'(64'd1 << (FRACTION_BITS + 2));

   // Clamp a one-bit-wider sum to the data range
   function automatic data_type sat_sum(input logic signed [DATA_WIDTH:0] v);
      data_type r;
      if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
         r = v[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // Clamp a shifted product to the data range
   function automatic data_type sat_product(input prod_type v);
      logic [PROD_WIDTH-DATA_WIDTH:0] upper;
      data_type r;
      upper = v[PROD_WIDTH-1:DATA_WIDTH-1];
      if ((&upper) || (~|upper)) begin
         r = v[DATA_WIDTH-1:0];
      end else begin
         r = v[PROD_WIDTH-1] ? DATA_MIN : DATA_MAX;
      end
      return r;
   endfunction

   function automatic data_type sat_add(input data_type a, input data_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
      return sat_sum(s);
   endfunction

   function automatic data_type sat_sub(input data_type a, input data_type b);
      logic signed [DATA_WIDTH:0] s;
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
      return sat_sum(s);
   endfunction

endpackage

// ===== hdl/escape_time_fractal_iterator.sv =====
// Top level: escape-time fractal iterator (mandelbrot, julia, phoenix) in fixed point.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   start_real/imag, point_real/imag, start_count
//   rsp      out        rsp_valid/stall   iteration_count
//   csr      in         csr_write_enable  csr_index, csr_write_data
//
// One recurrence step runs on the single 32x32 multiplier: zr^2, zi^2, zr*zi, then
// a test/update step. A pixel occupies the block from its beat until its result is
// loaded, and the block passes through idle before it takes the next beat.
// Reset clears the sequencer, the result valid and the registers to their defaults.
// The result sits in an output register; a stalled result holds the block in its
// final test cycle only if a new result is ready before the old one is taken.
module escape_time_fractal_iterator (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  etfi_pkg::data_type       req_start_real,
   input  etfi_pkg::data_type       req_start_imag,
   input  etfi_pkg::data_type       req_point_real,
   input  etfi_pkg::data_type       req_point_imag,
   input  etfi_pkg::count_type      req_start_count,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output etfi_pkg::result_type     rsp_iteration_count,
   // configuration port
   input  logic                     csr_write_enable,
   input  etfi_pkg::csr_index_type  csr_index,
   input  etfi_pkg::data_type       csr_write_data
);
   import etfi_pkg::*;
   `include "escape_time_fractal_iterator_macros.svh"

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQR  = 3'd1;
   localparam logic [2:0] ST_SQI  = 3'd2;
   localparam logic [2:0] ST_NORM = 3'd3;
   localparam logic [2:0] ST_TEST = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_count_ff, rsp_count_in;
   mode_type    mode_ff, mode_in;
   count_type   max_ff, max_in;
   data_type    kr_ff, kr_in;
   data_type    ki_ff, ki_in;

   data_type    zr_ff, zr_in;
   data_type    zi_ff, zi_in;
   data_type    cr_ff, cr_in;
   data_type    ci_ff, ci_in;
   data_type    sq_r_ff, sq_r_in;
   data_type    sq_i_ff, sq_i_in;
   result_type  cnt_ff, cnt_in;
   logic        first_ff, first_in;

   mul_ctrl_type mul_ctrl;
   data_type     mul_op_a, mul_op_b;
   data_type     square_out, cross_out;

   logic        req_beat;
   logic        out_free;
   logic        phoenix;
   logic        stop;
   result_type  cnt_inc;
   data_type    norm;
   data_type    prev_r, prev_i, diff, next_r, next_i;

   assign req_beat = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign phoenix  = (mode_ff == MODE_PHOENIX);

   // Shared multiplier
   etfi_mult_unit u_mult (
      .clock      (clock),
      .mul_ctrl   (mul_ctrl),
      .mul_op_a   (mul_op_a),
      .mul_op_b   (mul_op_b),
      .square_out (square_out),
      .cross_out  (cross_out)
   );

   // Operand select per state
   always_comb begin
      mul_ctrl.load     = 1'b0;
      mul_ctrl.absolute = phoenix;
      mul_op_a          = zr_ff;
      mul_op_b          = zr_ff;
      unique case (state_ff)
         ST_SQR: begin
            mul_ctrl.load = 1'b1;
         end
         ST_SQI: begin
            mul_ctrl.load = 1'b1;
            mul_op_a      = zi_ff;
            mul_op_b      = zi_ff;
         end
         ST_NORM: begin
            mul_ctrl.load = 1'b1;
            mul_op_a      = zi_ff;
            mul_op_b      = zr_ff;
         end
         default: begin
            mul_ctrl.load = 1'b0;
         end
      endcase
   end

   // Test and next point
   always_comb begin
      norm    = sat_add(sq_r_ff, sq_i_ff);
      cnt_inc = cnt_ff + 1'b1;
      stop    = (cnt_inc >= {1'b0, max_ff}) || !(norm < FOUR_LIMIT);
      // phoenix uses the previous squares, zero before its first step
      prev_r  = (phoenix && first_ff) ? '0 : sq_r_ff;
      prev_i  = (phoenix && first_ff) ? '0 : sq_i_ff;
      diff    = sat_sub(prev_r, prev_i);
      next_r  = phoenix ? sat_sub(diff, cr_ff) : sat_add(diff, cr_ff);
      next_i  = sat_add(cross_out, ci_ff);
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      mode_in      = mode_ff;
      max_in       = max_ff;
      kr_in        = kr_ff;
      ki_in        = ki_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      sq_r_in      = sq_r_ff;
      sq_i_in      = sq_i_ff;
      cnt_in       = cnt_ff;
      first_in     = first_ff;

      // register writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:     mode_in = csr_write_data[MODE_WIDTH-1:0];
            CSR_MAX_ITER: max_in  = csr_write_data[COUNT_WIDTH-1:0];
            CSR_JULIA_RE: kr_in   = csr_write_data;
            CSR_JULIA_IM: ki_in   = csr_write_data;
            default:      mode_in = mode_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               zr_in    = req_start_real;
               zi_in    = req_start_imag;
               cr_in    = (mode_ff == MODE_JULIA) ? kr_ff : req_point_real;
               ci_in    = (mode_ff == MODE_JULIA) ? ki_ff : req_point_imag;
               cnt_in   = {1'b0, req_start_count};
               first_in = 1'b1;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            state_in = ST_SQI;
         end
         ST_SQI: begin
            sq_r_in  = square_out;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            sq_i_in  = square_out;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!stop) begin
               zr_in    = next_r;
               zi_in    = next_i;
               cnt_in   = cnt_inc;
               first_in = 1'b0;
               state_in = ST_SQR;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_inc;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RESET;
         max_ff       <= MAX_ITER_RESET;
         kr_ff        <= JULIA_RE_RESET;
         ki_ff        <= JULIA_IM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         max_ff       <= max_in;
         kr_ff        <= kr_in;
         ki_ff        <= ki_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      sq_r_ff      <= sq_r_in;
      sq_i_ff      <= sq_i_in;
      cnt_ff       <= cnt_in;
      first_ff     <= first_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

   // Assertions
   `ETFI_ASSERT(a_beat_starts, req_beat |=> (state_ff == ST_SQR), "accepted beat did not start")
   `ETFI_ASSERT(a_rsp_from_test, (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_TEST), "result loaded outside test cycle")
   `ETFI_ASSERT(a_count_step, (!$past(reset) && state_ff == ST_SQR && $past(state_ff) == ST_TEST) |-> (cnt_ff == $past(cnt_ff) + 1), "counter did not advance by one per step")
   `ETFI_ASSERT(a_hold_when_full, (state_ff == ST_TEST && stop && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_TEST && rsp_valid_ff), "finished item lost while result stalled")

endmodule

// ===== hdl/etfi_mult_unit.sv =====
// Shared signed multiplier with registered product and scaled, saturated outputs.
module etfi_mult_unit (
   input  logic                    clock,
   input  etfi_pkg::mul_ctrl_type  mul_ctrl,
   input  etfi_pkg::data_type      mul_op_a,
   input  etfi_pkg::data_type      mul_op_b,
   output etfi_pkg::data_type      square_out,
   output etfi_pkg::data_type      cross_out
);
   import etfi_pkg::*;

   prod_type prod_ff, prod_in;
   logic     absolute_ff;
   prod_type prod_mag;
   prod_type square_shift;
   prod_type cross_shift;

   // Full-precision product
   assign prod_in = mul_op_a * mul_op_b;

   // Product register, held while no new product is issued
   always_ff @(posedge clock) begin
      if (mul_ctrl.load) begin
         prod_ff     <= prod_in;
         absolute_ff <= mul_ctrl.absolute;
      end
   end

   // Magnitude never overflows: |a*b| is at most 2^(2*DATA_WIDTH-2)
   assign prod_mag = prod_ff[PROD_WIDTH-1] ? -prod_ff : prod_ff;

   // Arithmetic shift rounds toward minus infinity
   assign square_shift = prod_ff >>> FRACTION_BITS;
   assign cross_shift  = (absolute_ff ? prod_mag : prod_ff) >>> (FRACTION_BITS - 1);

   assign square_out = sat_product(square_shift);
   assign cross_out  = sat_product(cross_shift);

endmodule
